@@ sv/uxr_pkg.sv @@
`default_nettype none
package uxr_pkg;

  localparam int RX_DEPTH = 256;
  localparam int TX_DEPTH = 256;
  localparam int RX_AW = $clog2(RX_DEPTH);
  localparam int TX_AW = $clog2(TX_DEPTH);
  localparam int RX_CW = $clog2(RX_DEPTH + 1);
  localparam int TX_CW = $clog2(TX_DEPTH + 1);
  localparam int CMP_W = 16;

  localparam logic [7:0] CH_XON = 8'h11;
  localparam logic [7:0] CH_XOFF = 8'h13;
  localparam logic [7:0] OVERRUN_BIT = 8'h08;

  localparam logic [2:0] KIND_RX_CHAR = 3'd0;
  localparam logic [2:0] KIND_TX_READY = 3'd1;
  localparam logic [2:0] KIND_HOST_WRITE = 3'd2;
  localparam logic [2:0] KIND_HOST_READ = 3'd3;
  localparam logic [2:0] KIND_RX_RESTART = 3'd4;
  localparam logic [2:0] KIND_SET_STATUS = 3'd5;

  localparam logic [1:0] CFG_XONXOFF_ENABLE = 2'd0;
  localparam logic [1:0] CFG_RX_CAPACITY = 2'd1;
  localparam logic [1:0] CFG_RX_HIGH_WATERMARK = 2'd2;
  localparam logic [1:0] CFG_TX_LOW_WATERMARK = 2'd3;

  localparam int CFG_DW = 9;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic [7:0] line_status;
    logic [3:0] status_request;
  } uxr_in_t;

  typedef struct packed {
    logic       line_valid;
    logic [7:0] line_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       write_accepted;
    logic       wake;
    logic       rx_disabled;
    logic       tx_disabled;
    logic [7:0] rx_error_bits;
    logic [7:0] tx_error_bits;
  } uxr_out_t;

  typedef struct packed {
    logic xoff_in;
    logic xoff_out;
    logic xoff_pend;
    logic xon_pend;
  } uxr_flow_t;

  typedef struct packed {
    uxr_flow_t        flow;
    logic             tx_enabled;
    logic [RX_CW-1:0] rx_fill;
    logic [TX_CW-1:0] tx_fill;
    logic [7:0]       rx_err;
    logic [7:0]       tx_err;
  } uxr_state_t;

  typedef struct packed {
    logic rx_push;
    logic rx_pop;
    logic tx_push;
    logic tx_pop;
  } uxr_ring_op_t;

  typedef struct packed {
    logic       xonxoff_enable;
    logic [8:0] rx_capacity;
    logic [8:0] rx_high_watermark;
    logic [7:0] tx_low_watermark;
  } uxr_cfg_t;

endpackage
`default_nettype wire

@@ sv/uart_xonxoff_ring_buffer_control.sv @@
`default_nettype none
// Channel   Handshake              Payload
// in_       in_valid / in_stall    in_data   (uxr_in_t)
// out_      out_valid / out_stall  out_data  (uxr_out_t)
// cfg_      cfg_we                 cfg_index, cfg_wdata
//
// One item per cycle sustained while out_stall is low. An accepted item is registered, then processed
// in one pass (flag/pointer update plus one access per ring RAM, registered
// read), and its result then moves from the processing register into the output register.
// Output stall backs up through the processing and input stages to in_stall.
// Reset clears pointers, fills and error records, leaves only XOFF-sent set and
// restores register defaults; the rings need no clearing, so items are taken
// right after reset.
module uart_xonxoff_ring_buffer_control
  import uxr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire uxr_in_t           in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output uxr_out_t               out_data,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_wdata
);

  localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
  localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);

  logic [7:0] rx_mem [RX_DEPTH];
  logic [7:0] tx_mem [TX_DEPTH];
  logic [7:0] rx_rd_r;
  logic [7:0] tx_rd_r;

  uxr_in_t    in_r;
  logic       i_valid_r;
  uxr_out_t   a_res_r;
  logic       a_line_mem_r;
  logic       a_valid_r;
  uxr_out_t   out_r;
  logic       out_valid_r;

  uxr_state_t st_r;
  uxr_state_t st_nxt;
  uxr_cfg_t   cfg_r;
  logic [RX_AW-1:0] rx_wptr_r;
  logic [RX_AW-1:0] rx_rptr_r;
  logic [TX_AW-1:0] tx_wptr_r;
  logic [TX_AW-1:0] tx_rptr_r;

  uxr_ring_op_t ops;
  uxr_out_t     res;
  logic         line_from_ring;
  uxr_out_t     out_nxt;

  logic b_free;
  logic a_free;
  logic a_go;
  logic i_go;
  logic in_take;

  uxr_step u_step (
    .item           (in_r),
    .st             (st_r),
    .cfg            (cfg_r),
    .st_nxt         (st_nxt),
    .ops            (ops),
    .res            (res),
    .line_from_ring (line_from_ring)
  );

  always_comb begin
    b_free = !out_valid_r || !out_stall;
    a_free = !a_valid_r || b_free;
    a_go = a_valid_r && b_free;
    i_go = i_valid_r && a_free;
    in_stall = i_valid_r && !a_free;
    in_take = in_valid && !in_stall;
    out_valid = out_valid_r;
    out_data = out_r;

    out_nxt = a_res_r;
    if (a_line_mem_r) begin
      out_nxt.line_byte = tx_rd_r;
    end
    if (a_res_r.read_valid) begin
      out_nxt.read_byte = rx_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (i_go && ops.rx_push) begin
      rx_mem[rx_wptr_r] <= in_r.data_byte;
    end
    if (i_go && ops.rx_pop) begin
      rx_rd_r <= rx_mem[rx_rptr_r];
    end
    if (i_go && ops.tx_push) begin
      tx_mem[tx_wptr_r] <= in_r.data_byte;
    end
    if (i_go && ops.tx_pop) begin
      tx_rd_r <= tx_mem[tx_rptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_data;
    end
    if (i_go) begin
      a_res_r <= res;
      a_line_mem_r <= line_from_ring;
    end
    if (a_go) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_valid_r <= 1'b0;
      a_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      st_r.flow <= '{xoff_in: 1'b0, xoff_out: 1'b1, xoff_pend: 1'b0, xon_pend: 1'b0};
      st_r.tx_enabled <= 1'b0;
      st_r.rx_fill <= '0;
      st_r.tx_fill <= '0;
      st_r.rx_err <= '0;
      st_r.tx_err <= '0;
      cfg_r.xonxoff_enable <= 1'b0;
      cfg_r.rx_capacity <= 9'd256;
      cfg_r.rx_high_watermark <= 9'd192;
      cfg_r.tx_low_watermark <= 8'd0;
      rx_wptr_r <= '0;
      rx_rptr_r <= '0;
      tx_wptr_r <= '0;
      tx_rptr_r <= '0;
    end else begin
      if (in_take) begin
        i_valid_r <= 1'b1;
      end else if (i_go) begin
        i_valid_r <= 1'b0;
      end
      if (i_go) begin
        a_valid_r <= 1'b1;
      end else if (a_go) begin
        a_valid_r <= 1'b0;
      end
      if (a_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_index)
          CFG_XONXOFF_ENABLE: begin
            if (cfg_wdata[0]) begin
              if (!cfg_r.xonxoff_enable) begin
                cfg_r.xonxoff_enable <= 1'b1;
                st_r.flow <= '{xoff_in: 1'b0, xoff_out: 1'b1,
                               xoff_pend: 1'b0, xon_pend: 1'b0};
              end
            end else begin
              cfg_r.xonxoff_enable <= 1'b0;
              st_r.flow <= '0;
            end
          end
          CFG_RX_CAPACITY:       cfg_r.rx_capacity <= cfg_wdata;
          CFG_RX_HIGH_WATERMARK: cfg_r.rx_high_watermark <= cfg_wdata;
          CFG_TX_LOW_WATERMARK:  cfg_r.tx_low_watermark <= cfg_wdata[7:0];
          default:               cfg_r <= cfg_r;
        endcase
      end else if (i_go) begin
        st_r <= st_nxt;
        if (ops.rx_push) begin
          rx_wptr_r <= (rx_wptr_r == RX_LAST) ? '0 : rx_wptr_r + RX_AW'(1);
        end
        if (ops.rx_pop) begin
          rx_rptr_r <= (rx_rptr_r == RX_LAST) ? '0 : rx_rptr_r + RX_AW'(1);
        end
        if (ops.tx_push) begin
          tx_wptr_r <= (tx_wptr_r == TX_LAST) ? '0 : tx_wptr_r + TX_AW'(1);
        end
        if (ops.tx_pop) begin
          tx_rptr_r <= (tx_rptr_r == TX_LAST) ? '0 : tx_rptr_r + TX_AW'(1);
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/uxr_step.sv @@
`default_nettype none
module uxr_step
  import uxr_pkg::*;
(
  input  wire uxr_in_t    item,
  input  wire uxr_state_t st,
  input  wire uxr_cfg_t   cfg,
  output uxr_state_t   st_nxt,
  output uxr_ring_op_t ops,
  output uxr_out_t     res,
  output logic         line_from_ring
);

  logic [CMP_W-1:0] cap;
  logic [CMP_W-1:0] rx_fill_w;
  logic [CMP_W-1:0] tx_left_w;
  logic [TX_CW-1:0] tx_left;
  logic             en;

  always_comb begin
    en = cfg.xonxoff_enable;
    rx_fill_w = CMP_W'(st.rx_fill);
    cap = (CMP_W'(cfg.rx_capacity) < CMP_W'(RX_DEPTH)) ? CMP_W'(cfg.rx_capacity)
                                                       : CMP_W'(RX_DEPTH);
    tx_left = st.tx_fill - TX_CW'(1);
    tx_left_w = CMP_W'(tx_left);

    st_nxt = st;
    ops = '0;
    res = '0;
    line_from_ring = 1'b0;

    case (item.kind)
      KIND_RX_CHAR: begin
        st_nxt.rx_err = st.rx_err | item.line_status;
        if (en && item.data_byte == CH_XOFF) begin
          st_nxt.tx_enabled = 1'b0;
          st_nxt.flow.xoff_in = 1'b1;
        end else if (en && item.data_byte == CH_XON) begin
          st_nxt.tx_enabled = 1'b1;
          st_nxt.flow.xoff_in = 1'b0;
        end else if (rx_fill_w >= cap) begin
          st_nxt.rx_err = st.rx_err | item.line_status | OVERRUN_BIT;
        end else begin
          if (st.rx_fill == '0) begin
            res.wake = 1'b1;
          end else if (en && (rx_fill_w + CMP_W'(1)) >= CMP_W'(cfg.rx_high_watermark)
                       && !st.flow.xoff_out) begin
            if (st.tx_enabled) begin
              res.line_valid = 1'b1;
              res.line_byte = CH_XOFF;
              st_nxt.flow.xoff_out = 1'b1;
              st_nxt.flow.xoff_pend = 1'b0;
            end else begin
              st_nxt.flow.xoff_pend = 1'b1;
            end
          end
          ops.rx_push = 1'b1;
          st_nxt.rx_fill = st.rx_fill + RX_CW'(1);
        end
      end
      KIND_TX_READY: begin
        if (!st.tx_enabled) begin
          st_nxt = st;
        end else if (st.flow.xon_pend || st.flow.xoff_pend) begin
          res.line_valid = 1'b1;
          if (st.flow.xoff_pend) begin
            res.line_byte = CH_XOFF;
            st_nxt.flow.xoff_out = 1'b1;
          end else begin
            res.line_byte = CH_XON;
            st_nxt.flow.xoff_out = 1'b0;
          end
          st_nxt.flow.xon_pend = 1'b0;
          st_nxt.flow.xoff_pend = 1'b0;
        end else if (st.flow.xoff_in) begin
          st_nxt.tx_enabled = 1'b0;
        end else if (st.tx_fill != '0) begin
          ops.tx_pop = 1'b1;
          st_nxt.tx_fill = tx_left;
          st_nxt.tx_err = st.tx_err | item.line_status;
          res.line_valid = 1'b1;
          line_from_ring = 1'b1;
          if (tx_left_w == CMP_W'(cfg.tx_low_watermark)) begin
            res.wake = 1'b1;
          end
          if (tx_left == '0) begin
            st_nxt.tx_enabled = 1'b0;
            res.wake = 1'b1;
          end
        end else begin
          st_nxt.tx_enabled = 1'b0;
          res.wake = 1'b1;
        end
      end
      KIND_HOST_WRITE: begin
        if (CMP_W'(st.tx_fill) < CMP_W'(TX_DEPTH)) begin
          ops.tx_push = 1'b1;
          st_nxt.tx_fill = st.tx_fill + TX_CW'(1);
          st_nxt.tx_enabled = 1'b1;
          res.write_accepted = 1'b1;
        end
      end
      KIND_HOST_READ: begin
        if (st.rx_fill != '0) begin
          ops.rx_pop = 1'b1;
          st_nxt.rx_fill = st.rx_fill - RX_CW'(1);
          res.read_valid = 1'b1;
        end
      end
      KIND_RX_RESTART: begin
        if (en && st.flow.xoff_out) begin
          if (st.tx_enabled) begin
            res.line_valid = 1'b1;
            res.line_byte = CH_XON;
            st_nxt.flow.xon_pend = 1'b0;
          end else begin
            st_nxt.flow.xon_pend = 1'b1;
          end
          st_nxt.flow.xoff_out = 1'b0;
          st_nxt.flow.xoff_pend = 1'b0;
        end
      end
      KIND_SET_STATUS: begin
        if (en) begin
          if (item.status_request[0]) begin
            st_nxt.flow.xoff_out = 1'b0;
          end else if (item.status_request[1]) begin
            st_nxt.flow.xoff_out = 1'b1;
          end
          if (item.status_request[2]) begin
            st_nxt.flow.xoff_in = 1'b0;
          end else if (item.status_request[3]) begin
            st_nxt.flow.xoff_in = 1'b1;
          end
        end
      end
      default: begin
        st_nxt = st;
      end
    endcase

    res.rx_disabled = en && st_nxt.flow.xoff_out;
    res.tx_disabled = en && st_nxt.flow.xoff_in;
    res.rx_error_bits = st_nxt.rx_err;
    res.tx_error_bits = st_nxt.tx_err;
  end

endmodule
`default_nettype wire

@@ sim/uart_xonxoff_ring_buffer_control_tb.sv @@
`timescale 1ns / 1ps
module uart_xonxoff_ring_buffer_control_tb;
  import uxr_pkg::*;

  localparam logic [2:0] KIND_SPARE_A = 3'd6;
  localparam logic [2:0] KIND_SPARE_B = 3'd7;
  localparam int QUIET_LIMIT = 2000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  uxr_in_t             in_data;
  logic                out_valid;
  logic                out_stall;
  uxr_out_t            out_data;
  logic                cfg_we;
  logic [1:0]          cfg_index;
  logic [CFG_DW-1:0]   cfg_wdata;

  uart_xonxoff_ring_buffer_control DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  logic [7:0] rx_mem [0:255];
  logic [7:0] tx_mem [0:255];
  logic [8:0] rx_cnt;
  logic [8:0] tx_cnt;
  logic [7:0] rx_wp, rx_rp, tx_wp, tx_rp;
  uxr_flow_t  flags;
  logic       tx_on;
  logic [7:0] rx_err, tx_err;
  uxr_cfg_t   cfg_model;

  uxr_out_t uart_results_due [$];
  int mismatches;
  int items_sent;
  int results_seen;
  int line_bytes;
  int host_reads;
  int quiet_cycles;
  bit no_idle;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= !no_idle && ($urandom_range(0, 99) < 21);
  end

  function automatic uxr_in_t uart_item(logic [2:0] kind, logic [7:0] data, logic [7:0] ls,
                                        logic [3:0] req);
    uxr_in_t it;
    it.kind = kind;
    it.data_byte = data;
    it.line_status = ls;
    it.status_request = req;
    return it;
  endfunction

  function automatic uxr_out_t advance_uart_model(uxr_in_t it);
    uxr_out_t   r;
    logic [8:0] cap;
    logic [8:0] cnt;
    logic       en;
    r = '0;
    en = cfg_model.xonxoff_enable;
    cap = (cfg_model.rx_capacity < 9'd256) ? cfg_model.rx_capacity : 9'd256;
    case (it.kind)
      KIND_RX_CHAR: begin
        rx_err |= it.line_status;
        if (en && it.data_byte == CH_XOFF) begin
          tx_on = 1'b0;
          flags.xoff_in = 1'b1;
        end else if (en && it.data_byte == CH_XON) begin
          tx_on = 1'b1;
          flags.xoff_in = 1'b0;
        end else if (rx_cnt >= cap) begin
          rx_err |= OVERRUN_BIT;
        end else begin
          cnt = rx_cnt + 9'd1;
          if (rx_cnt == 9'd0) begin
            r.wake = 1'b1;
          end else if (en && cnt >= cfg_model.rx_high_watermark && !flags.xoff_out) begin
            if (tx_on) begin
              r.line_valid = 1'b1;
              r.line_byte = CH_XOFF;
              flags.xoff_out = 1'b1;
              flags.xoff_pend = 1'b0;
            end else begin
              flags.xoff_pend = 1'b1;
            end
          end
          rx_mem[rx_wp] = it.data_byte;
          rx_wp = rx_wp + 8'd1;
          rx_cnt = cnt;
        end
      end
      KIND_TX_READY: begin
        if (!tx_on) begin
        end else if (flags.xon_pend || flags.xoff_pend) begin
          r.line_valid = 1'b1;
          if (flags.xoff_pend) begin
            r.line_byte = CH_XOFF;
            flags.xoff_out = 1'b1;
          end else begin
            r.line_byte = CH_XON;
            flags.xoff_out = 1'b0;
          end
          flags.xon_pend = 1'b0;
          flags.xoff_pend = 1'b0;
        end else if (flags.xoff_in) begin
          tx_on = 1'b0;
        end else begin
          if (tx_cnt > 9'd0) begin
            tx_cnt = tx_cnt - 9'd1;
            tx_err |= it.line_status;
            r.line_valid = 1'b1;
            r.line_byte = tx_mem[tx_rp];
            tx_rp = tx_rp + 8'd1;
            if (tx_cnt == {1'b0, cfg_model.tx_low_watermark}) r.wake = 1'b1;
          end
          if (tx_cnt == 9'd0) begin
            tx_on = 1'b0;
            r.wake = 1'b1;
          end
        end
      end
      KIND_HOST_WRITE: begin
        if (tx_cnt < 9'd256) begin
          tx_mem[tx_wp] = it.data_byte;
          tx_wp = tx_wp + 8'd1;
          tx_cnt = tx_cnt + 9'd1;
          r.write_accepted = 1'b1;
          tx_on = 1'b1;
        end
      end
      KIND_HOST_READ: begin
        if (rx_cnt > 9'd0) begin
          r.read_valid = 1'b1;
          r.read_byte = rx_mem[rx_rp];
          rx_rp = rx_rp + 8'd1;
          rx_cnt = rx_cnt - 9'd1;
        end
      end
      KIND_RX_RESTART: begin
        if (en && flags.xoff_out) begin
          if (tx_on) begin
            r.line_valid = 1'b1;
            r.line_byte = CH_XON;
            flags.xon_pend = 1'b0;
          end else begin
            flags.xon_pend = 1'b1;
          end
          flags.xoff_out = 1'b0;
          flags.xoff_pend = 1'b0;
        end
      end
      KIND_SET_STATUS: begin
        if (en) begin
          if (it.status_request[0]) flags.xoff_out = 1'b0;
          else if (it.status_request[1]) flags.xoff_out = 1'b1;
          if (it.status_request[2]) flags.xoff_in = 1'b0;
          else if (it.status_request[3]) flags.xoff_in = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.rx_disabled = en && flags.xoff_out;
    r.tx_disabled = en && flags.xoff_in;
    r.rx_error_bits = rx_err;
    r.tx_error_bits = tx_err;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at result %0d: %s", results_seen, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %02h want %02h", name, got, want));
  endtask

  always @(posedge clk) begin
    uxr_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (uart_results_due.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        want = uart_results_due.pop_front();
        compare_field("line_valid", out_data.line_valid, want.line_valid);
        compare_field("line_byte", out_data.line_byte, want.line_byte);
        compare_field("read_valid", out_data.read_valid, want.read_valid);
        compare_field("read_byte", out_data.read_byte, want.read_byte);
        compare_field("write_accepted", out_data.write_accepted, want.write_accepted);
        compare_field("wake", out_data.wake, want.wake);
        compare_field("rx_disabled", out_data.rx_disabled, want.rx_disabled);
        compare_field("tx_disabled", out_data.tx_disabled, want.tx_disabled);
        compare_field("rx_error_bits", out_data.rx_error_bits, want.rx_error_bits);
        compare_field("tx_error_bits", out_data.tx_error_bits, want.tx_error_bits);
        if (want.line_valid) line_bytes++;
        if (want.read_valid) host_reads++;
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
      $display("uart_xonxoff_ring_buffer_control_tb: errors");
      $finish;
    end
  end

  task automatic send_item(input uxr_in_t item);
    while (!no_idle && $urandom_range(0, 99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    uart_results_due.push_back(advance_uart_model(item));
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (uart_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_XONXOFF_ENABLE: begin
        if (val[0]) begin
          if (!cfg_model.xonxoff_enable) begin
            cfg_model.xonxoff_enable = 1'b1;
            flags = '0;
            flags.xoff_out = 1'b1;
          end
        end else begin
          cfg_model.xonxoff_enable = 1'b0;
          flags = '0;
        end
      end
      CFG_RX_CAPACITY: cfg_model.rx_capacity = val;
      CFG_RX_HIGH_WATERMARK: cfg_model.rx_high_watermark = val;
      default: cfg_model.tx_low_watermark = val[7:0];
    endcase
  endtask

  task automatic configure(input bit en, input logic [8:0] cap, input logic [8:0] hw,
                           input logic [7:0] lw);
    write_reg(CFG_XONXOFF_ENABLE, 9'd0);
    write_reg(CFG_XONXOFF_ENABLE, {8'd0, en});
    write_reg(CFG_RX_CAPACITY, cap);
    write_reg(CFG_RX_HIGH_WATERMARK, hw);
    write_reg(CFG_TX_LOW_WATERMARK, {1'b0, lw});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(input int count, input int w_rx, input int w_tick, input int w_wr,
                            input int w_rd, input int w_rst, input int w_st, input int w_spare,
                            input int flow_pct, input int pause_at);
    uxr_in_t item;
    int      total;
    int      pick;
    total = w_rx + w_tick + w_wr + w_rd + w_rst + w_st + w_spare;
    for (int n = 0; n < count; n++) begin
      if (n == pause_at) wait_drained();
      pick = $urandom_range(0, total - 1);
      if (pick < w_rx) item.kind = KIND_RX_CHAR;
      else if (pick < w_rx + w_tick) item.kind = KIND_TX_READY;
      else if (pick < w_rx + w_tick + w_wr) item.kind = KIND_HOST_WRITE;
      else if (pick < w_rx + w_tick + w_wr + w_rd) item.kind = KIND_HOST_READ;
      else if (pick < w_rx + w_tick + w_wr + w_rd + w_rst) item.kind = KIND_RX_RESTART;
      else if (pick < total - w_spare) item.kind = KIND_SET_STATUS;
      else item.kind = $urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B;
      if ($urandom_range(0, 99) < flow_pct)
        item.data_byte = $urandom_range(0, 1) ? CH_XON : CH_XOFF;
      else
        item.data_byte = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 8)
        item.line_status = 8'd1 << $urandom_range(0, 7);
      else
        item.line_status = 8'd0;
      item.status_request = 4'($urandom_range(0, 15));
      send_item(item);
    end
    wait_drained();
  endtask

  task automatic test_directed();
    configure(1'b1, 9'd2, 9'd2, 8'd1);
    send_item(uart_item(KIND_RX_CHAR, 8'h00, 8'h00, 4'h0));
    send_item(uart_item(KIND_RX_CHAR, 8'hFF, 8'h01, 4'hF));
    send_item(uart_item(KIND_RX_CHAR, 8'h5A, 8'h00, 4'h0));
    send_item(uart_item(KIND_SET_STATUS, 8'h00, 8'h00, 4'h1));
    send_item(uart_item(KIND_HOST_READ, 8'h00, 8'h00, 4'h0));
    send_item(uart_item(KIND_RX_CHAR, 8'h80, 8'h00, 4'h0));
    send_item(uart_item(KIND_HOST_WRITE, 8'hFF, 8'h00, 4'h0));
    send_item(uart_item(KIND_HOST_WRITE, 8'h00, 8'h00, 4'h0));
    send_item(uart_item(KIND_TX_READY, 8'h00, 8'h00, 4'h0));
    send_item(uart_item(KIND_RX_RESTART, 8'h00, 8'h00, 4'h0));
    send_item(uart_item(KIND_TX_READY, 8'h00, 8'h80, 4'h0));
    send_item(uart_item(KIND_RX_CHAR, CH_XOFF, 8'h00, 4'h0));
    send_item(uart_item(KIND_TX_READY, 8'h00, 8'h40, 4'h0));
    send_item(uart_item(KIND_RX_CHAR, CH_XON, 8'h00, 4'h0));
    send_item(uart_item(KIND_SET_STATUS, 8'h00, 8'h00, 4'hA));
    send_item(uart_item(KIND_TX_READY, 8'h00, 8'h00, 4'h0));
    send_item(uart_item(KIND_SET_STATUS, 8'h00, 8'h00, 4'hF));
    send_item(uart_item(KIND_HOST_WRITE, CH_XOFF, 8'h00, 4'h0));
    send_item(uart_item(KIND_TX_READY, 8'h00, 8'h00, 4'h0));
    send_item(uart_item(KIND_TX_READY, 8'h00, 8'h00, 4'h0));
    send_item(uart_item(KIND_HOST_READ, 8'h00, 8'h00, 4'h0));
    send_item(uart_item(KIND_HOST_READ, 8'h00, 8'h00, 4'h0));
    send_item(uart_item(KIND_HOST_READ, 8'h00, 8'h00, 4'h0));
    send_item(uart_item(KIND_SPARE_A, 8'hFF, 8'hFF, 4'hF));
    send_item(uart_item(KIND_SPARE_B, 8'hFF, 8'hFF, 4'hF));
    wait_drained();
  endtask

  task automatic test_flow_small_ring();
    configure(1'b1, 9'd8, 9'd5, 8'd2);
    run_random(230, 30, 20, 15, 20, 6, 6, 3, 12, -1);
  endtask

  task automatic test_rx_ring_overrun();
    configure(1'b1, 9'd256, 9'd256, 8'd0);
    run_random(380, 85, 3, 3, 3, 3, 2, 1, 5, -1);
  endtask

  task automatic test_tx_ring_full();
    no_idle = 1'b1;
    configure(1'b0, 9'd1, 9'd1, 8'd255);
    run_random(340, 3, 5, 88, 2, 1, 1, 1, 10, -1);
    no_idle = 1'b0;
  endtask

  task automatic test_mixed_with_pause();
    configure(1'b1, 9'd200, 9'd100, 8'd128);
    run_random(130, 20, 20, 20, 15, 8, 8, 4, 10, 65);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    no_idle = 1'b0;
    mismatches = 0;
    items_sent = 0;
    results_seen = 0;
    line_bytes = 0;
    host_reads = 0;
    rx_cnt = '0;
    tx_cnt = '0;
    rx_wp = '0;
    rx_rp = '0;
    tx_wp = '0;
    tx_rp = '0;
    flags = '0;
    flags.xoff_out = 1'b1;
    tx_on = 1'b0;
    rx_err = '0;
    tx_err = '0;
    cfg_model.xonxoff_enable = 1'b0;
    cfg_model.rx_capacity = 9'd256;
    cfg_model.rx_high_watermark = 9'd192;
    cfg_model.tx_low_watermark = 8'd0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_flow_small_ring();
    test_rx_ring_overrun();
    test_tx_ring_full();
    test_mixed_with_pause();
    wait_drained();
    if (uart_results_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", uart_results_due.size()));
    $display("run covered %0d items over five register settings", items_sent);
    $display("%0d bytes on the line, %0d host reads, %0d mismatches",
             line_bytes, host_reads, mismatches);
    if (mismatches == 0) begin
      $display("uart_xonxoff_ring_buffer_control_tb: clean");
    end else begin
      $display("uart_xonxoff_ring_buffer_control_tb: errors");
    end
    $finish;
  end

endmodule
